// ===== rtl/core/isp_pkg.sv =====
// Shared types and constants for the sample header parser.
package isp_pkg;

    localparam int MAX_IV_BYTES_DEF = 8;
    localparam int VALUE_W          = 64;
    localparam int FIFO_DEPTH       = 4;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SELECTIVE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IV_BYTES       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_IND_BYTES  = 2'd2;

    localparam logic [1:0] KIND_IV      = 2'd0;
    localparam logic [1:0] KIND_KEY_IND = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_STATUS  = 2'd3;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_final;
    } isp_in_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [VALUE_W-1:0] value;
        logic               encrypted;
        logic               status;
        logic               last_of_run;
    } isp_out_t;

    typedef struct packed {
        logic       selective_mode;
        logic [3:0] iv_bytes;
        logic [7:0] key_ind_bytes;
    } isp_cfg_t;

    typedef struct packed {
        logic [1:0] cnt;
        isp_out_t   r0;
        isp_out_t   r1;
    } isp_push_t;

endpackage

// ===== rtl/core/isp_parse.sv =====
// Per-byte header parse: phase, counters, vector gather and result generation.
module isp_parse #(
    parameter int MAX_IV_BYTES = isp_pkg::MAX_IV_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  isp_pkg::isp_in_t    item,
    input  isp_pkg::isp_cfg_t   cfg,
    output isp_pkg::isp_push_t  push
);

    localparam int         ACC_W     = 8 * MAX_IV_BYTES;
    localparam logic [3:0] MAX_IV_W  = 4'(MAX_IV_BYTES);

    typedef enum logic [3:0] {
        PH_FIRST = 4'b0001,
        PH_IV    = 4'b0010,
        PH_KI    = 4'b0100,
        PH_PAY   = 4'b1000
    } isp_phase_t;

    isp_phase_t       phase_reg, phase_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             enc_reg, enc_next;

    logic             first;
    logic             enc_cur;
    logic [3:0]       iv_eff;
    isp_phase_t       after_iv_ph;
    isp_phase_t       after_first_ph;
    isp_phase_t       ph;
    logic [7:0]       cnt;
    logic [7:0]       cnt_inc;
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] acc_sh;
    logic             consumed;
    logic             dat_valid;
    isp_pkg::isp_out_t dat;
    isp_pkg::isp_out_t st;

    assign first          = (phase_reg == PH_FIRST);
    assign enc_cur        = first ? (cfg.selective_mode ? item.byte_value[7] : 1'b1) : enc_reg;
    assign iv_eff         = (cfg.iv_bytes > MAX_IV_W) ? MAX_IV_W : cfg.iv_bytes;
    assign after_iv_ph    = (enc_cur && cfg.key_ind_bytes != 8'd0) ? PH_KI : PH_PAY;
    assign after_first_ph = (enc_cur && iv_eff != 4'd0) ? PH_IV : after_iv_ph;

    always_comb
    begin
        ph        = first ? after_first_ph : phase_reg;
        cnt       = first ? 8'd0 : cnt_reg;
        acc       = first ? '0 : acc_reg;
        consumed  = first && cfg.selective_mode;
        cnt_inc   = cnt + 8'd1;
        acc_sh    = (acc << 8) | ACC_W'(item.byte_value);
        dat_valid = 1'b0;
        dat       = '0;
        dat.encrypted = enc_cur;

        if (!consumed)
        begin
            dat_valid = 1'b1;
            priority if (ph == PH_IV)
            begin
                acc = acc_sh;
                cnt = cnt_inc;
                dat_valid = 1'b0;
                if (cnt_inc >= {4'd0, iv_eff})
                begin
                    dat_valid  = 1'b1;
                    dat.kind   = isp_pkg::KIND_IV;
                    dat.value  = isp_pkg::VALUE_W'(acc_sh);
                    cnt        = 8'd0;
                    ph         = after_iv_ph;
                end
            end
            else if (ph == PH_KI)
            begin
                dat.kind  = isp_pkg::KIND_KEY_IND;
                dat.value = isp_pkg::VALUE_W'(item.byte_value);
                cnt       = cnt_inc;
                if (cnt_inc >= cfg.key_ind_bytes)
                begin
                    cnt = 8'd0;
                    ph  = PH_PAY;
                end
            end
            else
            begin
                dat.kind  = isp_pkg::KIND_PAYLOAD;
                dat.value = isp_pkg::VALUE_W'(item.byte_value);
            end
        end

        st             = '0;
        st.kind        = isp_pkg::KIND_STATUS;
        st.encrypted   = enc_cur;
        st.status      = (ph == PH_IV) || (ph == PH_KI);
        st.last_of_run = 1'b1;

        phase_next = ph;
        cnt_next   = cnt;
        acc_next   = acc;
        enc_next   = enc_cur;
        if (item.is_final)
        begin
            phase_next = PH_FIRST;
            cnt_next   = 8'd0;
            acc_next   = '0;
            enc_next   = 1'b0;
        end

        push = '0;
        if (dat_valid)
        begin
            push.r0  = dat;
            push.r1  = st;
            push.cnt = item.is_final ? 2'd2 : 2'd1;
        end
        else
        begin
            push.r0  = st;
            push.r1  = st;
            push.cnt = item.is_final ? 2'd1 : 2'd0;
        end
        if (!accept)
        begin
            push.cnt = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            cnt_reg   <= 8'd0;
            acc_reg   <= '0;
            enc_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            enc_reg   <= enc_next;
        end
    end

endmodule

// ===== rtl/core/isp_out_fifo.sv =====
// Result queue: takes up to two items per cycle, hands out one per cycle unless res_stall.
module isp_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  isp_pkg::isp_push_t push,
    output logic               room,
    output logic               res_valid,
    input  logic               res_stall,
    output isp_pkg::isp_out_t  res_item
);

    localparam int PTR_W = $clog2(isp_pkg::FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(isp_pkg::FIFO_DEPTH - 2);

    isp_pkg::isp_out_t mem_reg [isp_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;

    assign res_valid = (count_reg != '0);
    assign res_item  = mem_reg[rd_ptr_reg];
    assign room      = (count_reg <= ROOM_MAX);
    assign pop       = res_valid && !res_stall;

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push.cnt) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/isma_sample_header_parser_unit.sv =====
// Top level of the sample header parser: config registers, parse stage, result queue.
//
//   channel   direction  handshake               payload
//   byte      in         byte_valid/byte_stall   byte_item (isp_in_t)
//   res       out        res_valid/res_stall     res_item (isp_out_t)
//   cfg       in         cfg_wr_en               cfg_index, cfg_wdata
//
// One byte item per cycle unless byte_stall; each byte gives zero, one or two result items.
// Result items are registered in the result queue before they appear; the queue sends one per cycle unless res_stall.
// Byte items stall while the queue has fewer than two free entries.
// Reset returns the parser to the first-byte phase and empties the queue.
module isma_sample_header_parser_unit #(
    parameter int MAX_IV_BYTES = isp_pkg::MAX_IV_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              byte_valid,
    output logic                              byte_stall,
    input  isp_pkg::isp_in_t                  byte_item,
    output logic                              res_valid,
    input  logic                              res_stall,
    output isp_pkg::isp_out_t                 res_item,
    input  logic                              cfg_wr_en,
    input  logic [isp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [isp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    isp_pkg::isp_cfg_t  cfg_reg;
    isp_pkg::isp_push_t push;
    logic               room;
    logic               accept;

    assign byte_stall = !room;
    assign accept     = byte_valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                isp_pkg::REG_SELECTIVE_MODE: cfg_reg.selective_mode <= cfg_wdata[0];
                isp_pkg::REG_IV_BYTES:       cfg_reg.iv_bytes       <= cfg_wdata[3:0];
                isp_pkg::REG_KEY_IND_BYTES:  cfg_reg.key_ind_bytes  <= cfg_wdata;
                default:                     cfg_reg                <= cfg_reg;
            endcase
        end
    end

    isp_parse #(
        .MAX_IV_BYTES (MAX_IV_BYTES)
    ) u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_item),
        .cfg    (cfg_reg),
        .push   (push)
    );

    isp_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_item.is_final |=> res_valid)
        else $error("final byte produced no result");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> res_valid)
        else $error("input stalled with empty result queue");

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.last_of_run |-> res_item.kind == isp_pkg::KIND_STATUS)
        else $error("last_of_run on a non-status result");

    a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.kind != isp_pkg::KIND_STATUS
            |-> !res_item.status && !res_item.last_of_run)
        else $error("status bits set on a data result");

endmodule
